### rtl/index_linked_list_concatenator_assert.svh
// Assertion macros used by the concatenator controller.
`ifndef INDEX_LINKED_LIST_CONCATENATOR_ASSERT_SVH
`define INDEX_LINKED_LIST_CONCATENATOR_ASSERT_SVH

// Same-cycle implication, held off while in reset.
`define ILC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset.
`define ILC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ilc_pkg.sv
// Package: sizes, codes, payload and control types of the list concatenator.
`default_nettype none

package ilc_pkg;

    localparam int LEN       = 1024;
    localparam int MAX_LISTS = 16;

    localparam int IDX_W   = 11;
    localparam int OP_W    = 3;
    localparam int LCNT_W  = 5;
    localparam int NODE_AW = $clog2(LEN);
    localparam int HEAD_AW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int CNT_W   = $clog2(LEN + 1);
    localparam int HOPS_W  = $clog2(LEN);

    localparam logic [IDX_W-1:0]  LEN_V      = IDX_W'(LEN);
    localparam logic [IDX_W-1:0]  LISTS_V    = IDX_W'(MAX_LISTS);
    localparam logic [LCNT_W-1:0] LISTS_N    = LCNT_W'(MAX_LISTS);
    localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(LEN);
    localparam logic [HOPS_W-1:0] HOPS_FULL  = HOPS_W'(LEN - 1);

    typedef enum logic [OP_W-1:0] {
        OP_WR_NEXT = 3'd0,
        OP_WR_HEAD = 3'd1,
        OP_RD_NEXT = 3'd2,
        OP_RD_HEAD = 3'd3,
        OP_CONNECT = 3'd4,
        OP_WALK    = 3'd5,
        OP_LENGTH  = 3'd6
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [IDX_W-1:0]  index;
        logic [IDX_W-1:0]  value;
        logic [LCNT_W-1:0] list_count;
        logic              loop_back;
        logic [IDX_W-1:0]  steps;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] result;
        logic             length_overflow;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_NEXT,
        ST_RD_HEAD,
        ST_WALK,
        ST_MEAS,
        ST_CN_FIRST,
        ST_CN_TAIL,
        ST_CN_NEXT,
        ST_CN_LINK,
        ST_CN_HEAD0,
        ST_DONE
    } ilc_state_t;

    // source of the next-table read address and of the node register
    typedef enum logic [2:0] {
        NSRC_INDEX,
        NSRC_RDATA,
        NSRC_HDATA,
        NSRC_NODE,
        NSRC_FIRST
    } nsrc_t;

    typedef enum logic [1:0] {
        HSEL_INDEX,
        HSEL_ZERO,
        HSEL_SLOT_INC
    } hsel_t;

    typedef enum logic [1:0] {
        NW_ITEM,
        NW_LINK,
        NW_LOOP
    } nwsel_t;

    typedef enum logic {
        HW_ITEM,
        HW_FIRST
    } hwsel_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_LEN,
        RES_INDEX,
        RES_RDATA,
        RES_HDATA,
        RES_COUNT,
        RES_COUNT_INC
    } res_sel_t;

    typedef struct packed {
        logic     load_item;
        nsrc_t    nsrc;
        logic     node_ld;
        hsel_t    hsel;
        logic     next_we;
        nwsel_t   nwsel;
        logic     head_we;
        hwsel_t   hwsel;
        logic     count_clr;
        logic     count_inc;
        logic     hops_clr;
        logic     hops_inc;
        logic     rem_ld;
        logic     rem_dec;
        logic     slot_clr;
        logic     slot_inc;
        logic     first_ld;
        logic     tail_ld;
        logic     res_ld;
        res_sel_t res_sel;
        logic     res_ovf;
        logic     out_ld;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_in_node;
        logic            idx_in_head;
        logic            lists_zero;
        logic            steps_zero;
        logic            link_end;
        logic            head_end;
        logic            hops_full;
        logic            count_full;
        logic            rem_last;
        logic            slot_last;
        logic            first_moved;
        logic            loop_back;
    } status_t;

endpackage

`default_nettype wire

### rtl/ilc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ilc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/ilc_datapath.sv
// Datapath: both tables, walk registers, result and output payload register.
`default_nettype none

module ilc_datapath (
    input  logic             clk,
    input  ilc_pkg::req_t    req,
    input  ilc_pkg::cmd_t    cmd,
    output ilc_pkg::status_t status,
    output ilc_pkg::rsp_t    rsp
);

    import ilc_pkg::*;

    req_t               item_reg;
    logic [NODE_AW-1:0] node_reg;
    logic [NODE_AW-1:0] tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [HOPS_W-1:0]  hops_reg;
    logic [IDX_W-1:0]   rem_reg;
    logic [LCNT_W-1:0]  slot_reg;
    logic [HEAD_AW-1:0] first_slot_reg;
    logic [IDX_W-1:0]   first_val_reg;
    logic [IDX_W-1:0]   res_reg;
    logic               ovf_reg;
    rsp_t               rsp_reg;

    logic [IDX_W-1:0]   link_data;
    logic [IDX_W-1:0]   head_data;
    logic [IDX_W-1:0]   src_val;
    logic [NODE_AW-1:0] next_waddr;
    logic [IDX_W-1:0]   next_wdata;
    logic [HEAD_AW-1:0] head_waddr;
    logic [IDX_W-1:0]   head_wdata;
    logic [HEAD_AW-1:0] head_raddr;
    logic [LCNT_W-1:0]  lists_n;
    logic [LCNT_W-1:0]  slot_inc;
    logic [CNT_W-1:0]   count_inc;
    logic [IDX_W-1:0]   res_val;

    assign lists_n   = (item_reg.list_count > LISTS_N) ? LISTS_N : item_reg.list_count;
    assign slot_inc  = slot_reg + LCNT_W'(1);
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        case (cmd.nsrc)
            NSRC_INDEX: src_val = item_reg.index;
            NSRC_RDATA: src_val = link_data;
            NSRC_HDATA: src_val = head_data;
            NSRC_NODE:  src_val = IDX_W'(node_reg);
            NSRC_FIRST: src_val = first_val_reg;
            default:    src_val = item_reg.index;
        endcase
    end

    always_comb
    begin
        case (cmd.nwsel)
            NW_ITEM:
            begin
                next_waddr = item_reg.index[NODE_AW-1:0];
                next_wdata = item_reg.value;
            end
            NW_LINK:
            begin
                next_waddr = tail_reg;
                next_wdata = head_data;
            end
            NW_LOOP:
            begin
                next_waddr = tail_reg;
                next_wdata = first_val_reg;
            end
            default:
            begin
                next_waddr = item_reg.index[NODE_AW-1:0];
                next_wdata = item_reg.value;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.hwsel)
            HW_ITEM:
            begin
                head_waddr = item_reg.index[HEAD_AW-1:0];
                head_wdata = item_reg.value;
            end
            HW_FIRST:
            begin
                head_waddr = '0;
                head_wdata = first_val_reg;
            end
            default:
            begin
                head_waddr = item_reg.index[HEAD_AW-1:0];
                head_wdata = item_reg.value;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.hsel)
            HSEL_INDEX:    head_raddr = item_reg.index[HEAD_AW-1:0];
            HSEL_ZERO:     head_raddr = '0;
            HSEL_SLOT_INC: head_raddr = slot_inc[HEAD_AW-1:0];
            default:       head_raddr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.res_sel)
            RES_ZERO:      res_val = '0;
            RES_LEN:       res_val = LEN_V;
            RES_INDEX:     res_val = item_reg.index;
            RES_RDATA:     res_val = link_data;
            RES_HDATA:     res_val = head_data;
            RES_COUNT:     res_val = IDX_W'(count_reg);
            RES_COUNT_INC: res_val = IDX_W'(count_inc);
            default:       res_val = '0;
        endcase
    end

    ilc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LEN)
    ) u_next_ram (
        .clk   (clk),
        .we    (cmd.next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (src_val[NODE_AW-1:0]),
        .rdata (link_data)
    );

    ilc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_LISTS)
    ) u_head_ram (
        .clk   (clk),
        .we    (cmd.head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.node_ld)
        begin
            node_reg <= src_val[NODE_AW-1:0];
        end
        if (cmd.tail_ld)
        begin
            tail_reg <= node_reg;
        end
        if (cmd.count_clr)
        begin
            count_reg <= '0;
        end
        else if (cmd.count_inc)
        begin
            count_reg <= count_inc;
        end
        if (cmd.hops_clr)
        begin
            hops_reg <= '0;
        end
        else if (cmd.hops_inc)
        begin
            hops_reg <= hops_reg + HOPS_W'(1);
        end
        if (cmd.rem_ld)
        begin
            rem_reg <= item_reg.steps;
        end
        else if (cmd.rem_dec)
        begin
            rem_reg <= rem_reg - IDX_W'(1);
        end
        if (cmd.slot_clr)
        begin
            slot_reg <= '0;
        end
        else if (cmd.slot_inc)
        begin
            slot_reg <= slot_inc;
        end
        if (cmd.first_ld)
        begin
            first_slot_reg <= slot_reg[HEAD_AW-1:0];
            first_val_reg  <= head_data;
        end
        if (cmd.res_ld)
        begin
            res_reg <= res_val;
            ovf_reg <= cmd.res_ovf;
        end
        if (cmd.out_ld)
        begin
            rsp_reg.result          <= res_reg;
            rsp_reg.length_overflow <= ovf_reg;
        end
    end

    assign status.op          = item_reg.operation;
    assign status.idx_in_node = (item_reg.index < LEN_V);
    assign status.idx_in_head = (item_reg.index < LISTS_V);
    assign status.lists_zero  = (lists_n == '0);
    assign status.steps_zero  = (item_reg.steps == '0);
    assign status.link_end    = (link_data >= LEN_V);
    assign status.head_end    = (head_data >= LEN_V);
    assign status.hops_full   = (hops_reg == HOPS_FULL);
    assign status.count_full  = (count_reg == COUNT_FULL);
    assign status.rem_last    = (rem_reg == IDX_W'(1));
    assign status.slot_last   = (slot_inc >= lists_n);
    assign status.first_moved = (first_slot_reg != '0);
    assign status.loop_back   = item_reg.loop_back;

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

### rtl/ilc_ctrl.sv
// Controller: sequences table accesses and walks, owns the output valid flag.
`default_nettype none

`include "index_linked_list_concatenator_assert.svh"

module ilc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  ilc_pkg::status_t status,
    output ilc_pkg::cmd_t    cmd
);

    import ilc_pkg::*;

    ilc_state_t state_reg;
    ilc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                case (status.op)
                    OP_WR_NEXT:
                    begin
                        cmd.next_we = status.idx_in_node;
                        cmd.nwsel   = NW_ITEM;
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = RES_ZERO;
                        state_next  = ST_DONE;
                    end
                    OP_WR_HEAD:
                    begin
                        cmd.head_we = status.idx_in_head;
                        cmd.hwsel   = HW_ITEM;
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = RES_ZERO;
                        state_next  = ST_DONE;
                    end
                    OP_RD_NEXT:
                    begin
                        cmd.nsrc = NSRC_INDEX;
                        if (status.idx_in_node)
                        begin
                            state_next = ST_RD_NEXT;
                        end
                        else
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_LEN;
                            state_next  = ST_DONE;
                        end
                    end
                    OP_RD_HEAD:
                    begin
                        cmd.hsel = HSEL_INDEX;
                        if (status.idx_in_head)
                        begin
                            state_next = ST_RD_HEAD;
                        end
                        else
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_LEN;
                            state_next  = ST_DONE;
                        end
                    end
                    OP_CONNECT:
                    begin
                        cmd.slot_clr = 1'b1;
                        cmd.hsel     = HSEL_ZERO;
                        if (status.lists_zero)
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_ZERO;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_CN_FIRST;
                        end
                    end
                    OP_WALK:
                    begin
                        cmd.nsrc    = NSRC_INDEX;
                        cmd.node_ld = 1'b1;
                        cmd.rem_ld  = 1'b1;
                        if (status.steps_zero || !status.idx_in_node)
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_INDEX;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    OP_LENGTH:
                    begin
                        cmd.nsrc      = NSRC_INDEX;
                        cmd.node_ld   = 1'b1;
                        cmd.count_clr = 1'b1;
                        if (status.idx_in_node)
                        begin
                            state_next = ST_MEAS;
                        end
                        else
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_ZERO;
                            state_next  = ST_DONE;
                        end
                    end
                    default:
                    begin
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = RES_ZERO;
                        state_next  = ST_DONE;
                    end
                endcase
            end

            ST_RD_NEXT:
            begin
                cmd.res_ld  = 1'b1;
                cmd.res_sel = RES_RDATA;
                state_next  = ST_DONE;
            end

            ST_RD_HEAD:
            begin
                cmd.res_ld  = 1'b1;
                cmd.res_sel = RES_HDATA;
                state_next  = ST_DONE;
            end

            ST_WALK:
            begin
                cmd.nsrc    = NSRC_RDATA;
                cmd.node_ld = 1'b1;
                cmd.rem_dec = 1'b1;
                if (status.link_end || status.rem_last)
                begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_RDATA;
                    state_next  = ST_DONE;
                end
            end

            ST_MEAS:
            begin
                cmd.nsrc = NSRC_RDATA;
                if (status.count_full || status.link_end)
                begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = status.count_full ? RES_COUNT : RES_COUNT_INC;
                    cmd.res_ovf = status.count_full;
                    // connect with loop: close the merged list onto head 0
                    cmd.next_we = (status.op == OP_CONNECT) && status.loop_back;
                    cmd.nwsel   = NW_LOOP;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.count_inc = 1'b1;
                    cmd.node_ld   = 1'b1;
                end
            end

            ST_CN_FIRST:
            begin
                if (!status.head_end)
                begin
                    cmd.first_ld = 1'b1;
                    cmd.nsrc     = NSRC_HDATA;
                    cmd.node_ld  = 1'b1;
                    cmd.hops_clr = 1'b1;
                    state_next   = ST_CN_TAIL;
                end
                else if (status.slot_last)
                begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_ZERO;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                    cmd.hsel     = HSEL_SLOT_INC;
                end
            end

            ST_CN_TAIL:
            begin
                if (!status.link_end && !status.hops_full)
                begin
                    cmd.nsrc     = NSRC_RDATA;
                    cmd.node_ld  = 1'b1;
                    cmd.hops_inc = 1'b1;
                end
                else
                begin
                    cmd.tail_ld = 1'b1;
                    if (status.slot_last)
                    begin
                        state_next = ST_CN_HEAD0;
                    end
                    else
                    begin
                        cmd.slot_inc = 1'b1;
                        cmd.hsel     = HSEL_SLOT_INC;
                        state_next   = ST_CN_NEXT;
                    end
                end
            end

            ST_CN_NEXT:
            begin
                if (!status.head_end)
                begin
                    cmd.next_we  = 1'b1;
                    cmd.nwsel    = NW_LINK;
                    cmd.nsrc     = NSRC_HDATA;
                    cmd.node_ld  = 1'b1;
                    cmd.hops_clr = 1'b1;
                    state_next   = ST_CN_LINK;
                end
                else if (status.slot_last)
                begin
                    state_next = ST_CN_HEAD0;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                    cmd.hsel     = HSEL_SLOT_INC;
                end
            end

            ST_CN_LINK:
            begin
                // read after the link write so a self link is seen
                cmd.nsrc   = NSRC_NODE;
                state_next = ST_CN_TAIL;
            end

            ST_CN_HEAD0:
            begin
                cmd.head_we   = status.first_moved;
                cmd.hwsel     = HW_FIRST;
                cmd.nsrc      = NSRC_FIRST;
                cmd.node_ld   = 1'b1;
                cmd.count_clr = 1'b1;
                state_next    = ST_MEAS;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

    `ILC_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_ld, !out_valid_reg || rsp_ready, "output overwritten")
    `ILC_ASSERT_NXT(a_accept_dispatch, clk, rst_n, req_valid && req_ready, state_reg == ST_DISPATCH, "accept lost")
    `ILC_ASSERT_NXT(a_done_delivers, clk, rst_n, state_reg == ST_DONE && !out_valid_reg, out_valid_reg, "result held back")
    `ILC_ASSERT_NXT(a_beat_clears, clk, rst_n, out_valid_reg && rsp_ready && !cmd.out_ld, !out_valid_reg, "result repeated")

endmodule

`default_nettype wire

### rtl/index_linked_list_concatenator.sv
// Top level of the index-linked list concatenator: controller plus datapath.
// One item at a time; next request beat taken the cycle after the result enters the output register.
// Work per request: a walk follows links, a length counts nodes until the end or saturation,
// and a connect scans head slots, searches each list for its tail, links the lists and then
// counts the merged length.
// Reset clears the controller and output valid only; both tables stay undefined until written.
`default_nettype none

module index_linked_list_concatenator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ilc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ilc_pkg::rsp_t rsp
);

    import ilc_pkg::*;

    // Command and status between the sequencer and the datapath.
    cmd_t    cmd;
    status_t status;

    // Sequencer: one state per access phase. A connect beat scans heads one
    // slot a cycle, follows each list to its tail one link a cycle, links the
    // tail to the next non-empty head, then counts the merged list and may close it to a loop.
    ilc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: next table (LEN deep) and head table in RAM, walk counters,
    // and the output register that parts the response side from the work.
    ilc_datapath u_datapath (
        .clk    (clk),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire
